>>> hw/rtl/drop_tail_queue_goodput_monitor_defines.svh
`ifndef DROP_TAIL_QUEUE_GOODPUT_MONITOR_DEFINES_SVH
`define DROP_TAIL_QUEUE_GOODPUT_MONITOR_DEFINES_SVH

// same-cycle implication on clk, disabled in reset
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, disabled in reset
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dtq_pkg.sv
package dtq_pkg;

  localparam int QUEUE_DEPTH = 512;
  localparam int MAX_SERVE   = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 10;
  localparam int RATE_W      = 5;
  localparam int THR_W       = 16;
  localparam int ID_W        = 16;
  localparam int SLOT_W      = ID_W + 1;
  localparam int CTR_W       = 32;
  localparam int KIND_W      = 3;
  localparam int ACT_W       = 2;
  localparam int IDX_W       = 2;
  localparam int CFG_W       = 16;

  localparam logic [ACT_W-1:0] ACT_ARRIVAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;

  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COLLAPSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

  localparam logic [IDX_W-1:0] REG_QUEUE_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_SERVE_RATE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd2;

  localparam logic [CNT_W-1:0]  LIMIT_RESET     = 10'd500;
  localparam logic [RATE_W-1:0] RATE_RESET      = 5'd5;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd13107;

  typedef struct packed {
    logic done;
    logic below;
  } mul_status_t;

endpackage

>>> hw/rtl/dtq_ram.sv
module dtq_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/dtq_mulcmp.sv
module dtq_mulcmp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dtq_pkg::THR_W-1:0]    threshold,
  input  logic [dtq_pkg::CTR_W-1:0]    total,
  input  logic [dtq_pkg::CTR_W-1:0]    good,
  output dtq_pkg::mul_status_t         status
);

  localparam int HALF_W = dtq_pkg::CTR_W / 2;
  localparam int PROD_W = dtq_pkg::THR_W + HALF_W;
  localparam int ACC_W  = dtq_pkg::THR_W + dtq_pkg::CTR_W;

  logic              busy;
  logic              phase;
  logic              done;
  logic [ACC_W-1:0]  acc;
  logic [HALF_W-1:0] operand;
  logic [PROD_W-1:0] prod;

  assign operand = phase ? total[dtq_pkg::CTR_W-1:HALF_W] : total[HALF_W-1:0];
  assign prod    = PROD_W'(threshold) * PROD_W'(operand);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= busy && phase;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (!phase) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + {prod, {HALF_W{1'b0}}};
      end
    end
  end

  assign status.done  = done;
  assign status.below = {good, {dtq_pkg::THR_W{1'b0}}} < acc;

endmodule

>>> hw/rtl/drop_tail_queue_goodput_monitor.sv
// Arrival or protocol error: result registered at the accepting edge.
// Tick: collapse check in the 16x16 multiplier (low half of the total, then high half),
// a decide step, then per served entry a RAM read and a result load, then back to idle.
// A halted tick does no work. Input waits for an idle sequencer and a free result register.
// Reset (synchronous, active high) clears pointers, occupancy, counters, halt flag
// and restores register defaults; queue storage is not cleared.
`include "drop_tail_queue_goodput_monitor_defines.svh"

module drop_tail_queue_goodput_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dtq_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dtq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtq_pkg::ACT_W-1:0]     action,
  input  logic [dtq_pkg::ID_W-1:0]      item_id,
  input  logic                          item_new,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtq_pkg::KIND_W-1:0]    kind,
  output logic [dtq_pkg::ID_W-1:0]      ack_id,
  output logic                          ack_new,
  output logic [dtq_pkg::CNT_W-1:0]     queue_count,
  output logic [dtq_pkg::CTR_W-1:0]     total_served,
  output logic [dtq_pkg::CTR_W-1:0]     good_served,
  output logic                          last
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]                   state;
  logic [dtq_pkg::CNT_W-1:0]    queue_limit;
  logic [dtq_pkg::RATE_W-1:0]   serve_rate;
  logic [dtq_pkg::THR_W-1:0]    ratio_floor;
  logic [dtq_pkg::PTR_W-1:0]    head_ptr;
  logic [dtq_pkg::PTR_W-1:0]    tail_ptr;
  logic [dtq_pkg::CNT_W-1:0]    occupancy;
  logic [dtq_pkg::CTR_W-1:0]    total_counter;
  logic [dtq_pkg::CTR_W-1:0]    good_counter;
  logic                         halted;
  logic [dtq_pkg::RATE_W-1:0]   remaining;
  logic                         last_pend;

  logic                         out_free;
  logic                         accept;
  logic [dtq_pkg::CNT_W-1:0]    limit_eff;
  logic [dtq_pkg::RATE_W-1:0]   rate_eff;
  logic                         admit;
  logic                         mul_start;
  dtq_pkg::mul_status_t         mul_status;
  logic                         ram_we;
  logic                         ram_re;
  logic [dtq_pkg::SLOT_W-1:0]   ram_rdata;
  logic [dtq_pkg::CTR_W-1:0]    total_inc;
  logic [dtq_pkg::CTR_W-1:0]    good_inc;
  logic [dtq_pkg::PTR_W-1:0]    head_next;
  logic [dtq_pkg::PTR_W-1:0]    tail_next;
  logic                         collapse_hit;
  logic                         out_load;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign limit_eff = (queue_limit > dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH)) ?
                     dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH) : queue_limit;
  assign rate_eff  = (serve_rate > dtq_pkg::RATE_W'(dtq_pkg::MAX_SERVE)) ?
                     dtq_pkg::RATE_W'(dtq_pkg::MAX_SERVE) : serve_rate;
  assign admit     = occupancy < limit_eff;
  assign ram_we    = accept && (action == dtq_pkg::ACT_ARRIVAL) && admit;
  assign mul_start = accept && (action == dtq_pkg::ACT_TICK) && !halted;
  assign ram_re    = (state == ST_READ) && (remaining != '0) && (occupancy != '0);
  assign total_inc = (total_counter == '1) ? total_counter : total_counter + 1'b1;
  assign good_inc  = (good_counter == '1) ? good_counter : good_counter + 1'b1;
  assign head_next = (head_ptr == dtq_pkg::PTR_W'(dtq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : head_ptr + 1'b1;
  assign tail_next = (tail_ptr == dtq_pkg::PTR_W'(dtq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : tail_ptr + 1'b1;
  assign collapse_hit = (total_counter != '0) && mul_status.below;
  assign out_load  = (accept && (action != dtq_pkg::ACT_TICK)) ||
                     ((state == ST_DECIDE) && collapse_hit && out_free) ||
                     ((state == ST_EMIT) && out_free);

  dtq_ram #(
    .DEPTH(dtq_pkg::QUEUE_DEPTH),
    .WIDTH(dtq_pkg::SLOT_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_ptr),
    .wdata({item_new, item_id}),
    .re   (ram_re),
    .raddr(head_ptr),
    .rdata(ram_rdata)
  );

  dtq_mulcmp u_mulcmp (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .threshold(ratio_floor),
    .total    (total_counter),
    .good     (good_counter),
    .status   (mul_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= dtq_pkg::LIMIT_RESET;
      serve_rate  <= dtq_pkg::RATE_RESET;
      ratio_floor <= dtq_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtq_pkg::REG_QUEUE_LIMIT: queue_limit <= cfg_data[dtq_pkg::CNT_W-1:0];
        dtq_pkg::REG_SERVE_RATE:  serve_rate <= cfg_data[dtq_pkg::RATE_W-1:0];
        dtq_pkg::REG_THRESHOLD:   ratio_floor <= cfg_data[dtq_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      occupancy     <= '0;
      total_counter <= '0;
      good_counter  <= '0;
      halted        <= 1'b0;
      remaining     <= '0;
      last_pend     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (action)
              dtq_pkg::ACT_ARRIVAL: begin
                ack_id       <= item_id;
                ack_new      <= item_new;
                total_served <= total_counter;
                good_served  <= good_counter;
                last         <= 1'b1;
                if (admit) begin
                  kind        <= dtq_pkg::KIND_QUEUED;
                  tail_ptr    <= tail_next;
                  occupancy   <= occupancy + 1'b1;
                  queue_count <= occupancy + 1'b1;
                end else begin
                  kind        <= dtq_pkg::KIND_DROPPED;
                  queue_count <= occupancy;
                end
              end
              dtq_pkg::ACT_TICK: begin
                if (!halted) begin
                  state <= ST_MUL;
                end
              end
              default: begin
                kind         <= dtq_pkg::KIND_ERROR;
                ack_id       <= '0;
                ack_new      <= 1'b0;
                queue_count  <= occupancy;
                total_served <= total_counter;
                good_served  <= good_counter;
                last         <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (mul_status.done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (collapse_hit) begin
            if (out_free) begin
              halted       <= 1'b1;
              kind         <= dtq_pkg::KIND_COLLAPSE;
              ack_id       <= '0;
              ack_new      <= 1'b0;
              queue_count  <= occupancy;
              total_served <= total_counter;
              good_served  <= good_counter;
              last         <= 1'b1;
              state        <= ST_IDLE;
            end
          end else begin
            remaining <= rate_eff;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          if (ram_re) begin
            head_ptr  <= head_next;
            occupancy <= occupancy - 1'b1;
            remaining <= remaining - 1'b1;
            last_pend <= (remaining == dtq_pkg::RATE_W'(1)) ||
                         (occupancy == dtq_pkg::CNT_W'(1));
            state     <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            kind          <= dtq_pkg::KIND_ACK;
            ack_id        <= ram_rdata[dtq_pkg::ID_W-1:0];
            ack_new       <= ram_rdata[dtq_pkg::ID_W];
            queue_count   <= occupancy;
            total_counter <= total_inc;
            total_served  <= total_inc;
            last          <= last_pend;
            if (ram_rdata[dtq_pkg::ID_W]) begin
              good_counter <= good_inc;
              good_served  <= good_inc;
            end else begin
              good_served <= good_counter;
            end
            state <= last_pend ? ST_IDLE : ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DTQ_ASSERT_NOW(a_occ_bound, 1'b1,
    occupancy <= dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH), "occupancy above depth")
  `DTQ_ASSERT_NOW(a_collapse_halts, out_valid && (kind == dtq_pkg::KIND_COLLAPSE),
    halted, "collapse without halt")
  `DTQ_ASSERT_NOW(a_ack_counted, out_valid && (kind == dtq_pkg::KIND_ACK),
    total_served != '0, "ack with zero total")
  `DTQ_ASSERT_NEXT(a_halted_tick, accept && (action == dtq_pkg::ACT_TICK) && halted,
    !out_valid && (state == ST_IDLE), "halted tick produced work")

endmodule
